@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/rqqs_pkg.sv @@
// ---------------------------------------------------------------------------
// Ready queue quantum scheduler package
// Shared codes and entry layout.
// ---------------------------------------------------------------------------
`default_nettype none
package rqqs_pkg;
   localparam int unsigned FUNC_W = 3;
   localparam int unsigned ID_W = 8;
   localparam int unsigned DIST_W = 11;
   localparam int unsigned TD_W = 10;
   localparam int unsigned CNT_W = 8;
   localparam int unsigned STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_ENQUEUE = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_CONSUME = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SETDIST = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SELECT = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   localparam logic CSR_NEAREST_MODE = 1'b0;
   localparam logic CSR_QUANTUM = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [CNT_W-1:0] cnt;
      logic [TD_W-1:0] tdist;
      logic known;
   } entry_type;
   localparam int unsigned ENTRY_W = ID_W + CNT_W + TD_W + 1;
endpackage
`default_nettype wire

@@ sv/rqqs_mem.sv @@
// ---------------------------------------------------------------------------
// Ready queue entry memory
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module rqqs_mem #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW = 4
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [AW-1:0] wr_addr,
   input wire rqqs_pkg::entry_type wr_data,
   input wire logic [AW-1:0] rd_addr,
   output rqqs_pkg::entry_type rd_data
);
   import rqqs_pkg::*;
   entry_type mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ sv/ready_queue_quantum_scheduler_top.sv @@
// ---------------------------------------------------------------------------
// Ready queue quantum scheduler
// Ordered client queue held in one memory, walked by a sequencer per transaction.
// ---------------------------------------------------------------------------
// Sequence: enqueue and undefined codes go straight to the done state; others scan entries
// one at a time from the head, and remove/requeue also move each later entry up and end in a tail step.
// The longest transaction is a remove or requeue of the head entry.
// Throughput: one transaction at a time; busy is high until rsp_valid.
// Reset: occupancy 0, nearest_mode 0, quantum 3; memory contents stay unknown.
// The result strobe is not stallable.
`default_nettype none
module ready_queue_quantum_scheduler_top #(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic [rqqs_pkg::FUNC_W-1:0] req_func,
   input wire logic [rqqs_pkg::ID_W-1:0] req_entry_id,
   input wire logic signed [rqqs_pkg::DIST_W-1:0] req_distance,
   output logic rsp_valid,
   output logic [rqqs_pkg::STATUS_W-1:0] rsp_status,
   output logic [rqqs_pkg::ID_W-1:0] rsp_chosen_id,
   output logic rsp_quantum_expired,
   input wire logic csr_we,
   input wire logic csr_index,
   input wire logic [7:0] csr_wdata
);
   import rqqs_pkg::*;
   `include "assert_macros.svh"

   localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned OW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [OW-1:0] DEPTH_O = OW'(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_SHIFT, S_TAIL, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [OW-1:0] occ_ff, occ_in;
   logic [OW-1:0] idx_ff, idx_in;          // next read address to issue
   logic rd_vld_ff, rd_vld_in;             // rd_data holds the entry read for pos_ff
   logic [OW-1:0] pos_ff, pos_in;          // position of data in rd_data
   logic [FUNC_W-1:0] func_ff, func_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic mode_ff, mode_in;
   logic [CNT_W-1:0] quant_ff, quant_in;
   entry_type save_ff, save_in;            // entry moved to tail
   logic best_vld_ff, best_vld_in;
   logic [TD_W-1:0] best_d_ff, best_d_in;
   logic [ID_W-1:0] best_id_ff, best_id_in;
   logic [STATUS_W-1:0] st_ff, st_in;
   logic [ID_W-1:0] ch_ff, ch_in;
   logic exp_ff, exp_in;
   logic vld_ff, vld_in;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type wr_data, rd_data;

   rqqs_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic [CNT_W:0] cnt_inc;
   assign cnt_inc = {1'b0, rd_data.cnt} + 1'b1;

   always_comb begin
      state_in = state_ff; occ_in = occ_ff; idx_in = idx_ff;
      rd_vld_in = 1'b0; pos_in = pos_ff;
      func_in = func_ff; id_in = id_ff; dist_in = dist_ff;
      mode_in = mode_ff; quant_in = quant_ff; save_in = save_ff;
      best_vld_in = best_vld_ff; best_d_in = best_d_ff; best_id_in = best_id_ff;
      st_in = st_ff; ch_in = ch_ff; exp_in = exp_ff; vld_in = 1'b0;
      wr_en = 1'b0; wr_addr = '0; wr_data = rd_data;
      rd_addr = idx_ff[AW-1:0];
      if (csr_we && state_ff == S_IDLE) begin
         if (csr_index == CSR_NEAREST_MODE) mode_in = csr_wdata[0];
         else quant_in = csr_wdata;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in = req_func; id_in = req_entry_id; dist_in = req_distance;
               st_in = ST_OK; ch_in = '0; exp_in = 1'b0; best_vld_in = 1'b0;
               idx_in = '0; pos_in = '0;
               priority if (req_func == FUNC_ENQUEUE) begin
                  if (occ_ff >= DEPTH_O) begin
                     st_in = ST_FULL;
                  end else begin
                     wr_en = 1'b1; wr_addr = occ_ff[AW-1:0];
                     wr_data = '{id: req_entry_id, cnt: '0, tdist: '0, known: 1'b0};
                     occ_in = occ_ff + 1'b1;
                  end
                  state_in = S_DONE;
               end else if (req_func == FUNC_REMOVE || req_func == FUNC_CONSUME
                            || req_func == FUNC_SETDIST || req_func == FUNC_SELECT) begin
                  if (occ_ff == '0) begin
                     st_in = ST_NOT_FOUND; state_in = S_DONE;
                  end else begin
                     rd_addr = '0; idx_in = OW'(1); rd_vld_in = 1'b1;
                     state_in = S_SCAN;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            // rd_data is entry at pos_ff
            if (idx_ff < occ_ff) begin
               rd_addr = idx_ff[AW-1:0];
            end
            if (func_ff == FUNC_SELECT) begin
               if (!mode_ff) begin
                  ch_in = rd_data.id; state_in = S_DONE;
               end else if (!rd_data.known) begin
                  ch_in = rd_data.id; state_in = S_DONE;
               end else begin
                  if (!best_vld_ff || rd_data.tdist < best_d_ff) begin
                     best_vld_in = 1'b1; best_d_in = rd_data.tdist;
                     best_id_in = rd_data.id;
                  end
                  if (pos_ff + 1'b1 >= occ_ff) begin
                     ch_in = (!best_vld_ff || rd_data.tdist < best_d_ff) ?
                             rd_data.id : best_id_ff;
                     state_in = S_DONE;
                  end else begin
                     idx_in = idx_ff + 1'b1; pos_in = pos_ff + 1'b1;
                  end
               end
            end else if (rd_data.id == id_ff) begin
               wr_addr = pos_ff[AW-1:0];
               if (func_ff == FUNC_REMOVE) begin
                  state_in = (pos_ff + 1'b1 >= occ_ff) ? S_TAIL : S_SHIFT;
                  idx_in = idx_ff + 1'b1; pos_in = pos_ff + 1'b1;
               end else if (func_ff == FUNC_SETDIST) begin
                  if (!dist_ff[DIST_W-1]) begin
                     wr_en = 1'b1;
                     wr_data.tdist = dist_ff[TD_W-1:0]; wr_data.known = 1'b1;
                  end
                  state_in = S_DONE;
               end else if (cnt_inc >= {1'b0, quant_ff}) begin
                  save_in = rd_data; save_in.cnt = '0; exp_in = 1'b1;
                  state_in = (pos_ff + 1'b1 >= occ_ff) ? S_TAIL : S_SHIFT;
                  idx_in = idx_ff + 1'b1; pos_in = pos_ff + 1'b1;
               end else begin
                  wr_en = 1'b1; wr_data.cnt = cnt_inc[CNT_W-1:0];
                  state_in = S_DONE;
               end
            end else if (pos_ff + 1'b1 >= occ_ff) begin
               st_in = ST_NOT_FOUND; state_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1; pos_in = pos_ff + 1'b1;
            end
         end
         S_SHIFT: begin
            // rd_data is the entry at pos_ff; it moves up to slot pos_ff-1
            // the read for pos_ff is issued here while rd_vld_ff is low
            if (!rd_vld_ff) begin
               rd_addr = pos_ff[AW-1:0]; rd_vld_in = 1'b1;
            end else begin
               wr_en = 1'b1; wr_addr = AW'(pos_ff - 1'b1); wr_data = rd_data;
               if (pos_ff + 1'b1 >= occ_ff) begin
                  state_in = S_TAIL;
               end
               pos_in = pos_ff + 1'b1;
            end
         end
         S_TAIL: begin
            if (func_ff == FUNC_CONSUME) begin
               wr_en = 1'b1; wr_addr = AW'(occ_ff - 1'b1); wr_data = save_ff;
            end else begin
               occ_in = occ_ff - 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            vld_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; occ_ff <= '0; mode_ff <= 1'b0; quant_ff <= 8'd3;
         vld_ff <= 1'b0; rd_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in; occ_ff <= occ_in; mode_ff <= mode_in;
         quant_ff <= quant_in; vld_ff <= vld_in; rd_vld_ff <= rd_vld_in;
      end
      idx_ff <= idx_in; pos_ff <= pos_in; func_ff <= func_in; id_ff <= id_in;
      dist_ff <= dist_in; save_ff <= save_in; best_vld_ff <= best_vld_in;
      best_d_ff <= best_d_in; best_id_ff <= best_id_in;
      st_ff <= st_in; ch_ff <= ch_in; exp_ff <= exp_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = vld_ff;
   assign rsp_status = st_ff;
   assign rsp_chosen_id = ch_ff;
   assign rsp_quantum_expired = exp_ff;

   `ASSERT_IMPL(a_occ_bound, clock, reset, 1'b1, occ_ff <= DEPTH_O, "occupancy overflow")
   `ASSERT_NEXT(a_done_strobe, clock, reset, state_ff == S_DONE, rsp_valid, "missing strobe")
   `ASSERT_IMPL(a_exp_ok, clock, reset, rsp_valid && rsp_quantum_expired,
                rsp_status == ST_OK, "expired with error status")
endmodule
`default_nettype wire

@@ sim/tb.sv @@
// ---------------------------------------------------------------------------
// Ready queue quantum scheduler testbench
// Drives scheduler events through the command port, tracks the ready queue
// in a local shadow and checks every response field against it.
// ---------------------------------------------------------------------------
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rqqs_pkg::*;

   localparam int DEPTH = 16;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ID_W-1:0] id;
      logic signed [DIST_W-1:0] tdist;
   } event_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0] chosen;
      logic expired;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [FUNC_W-1:0] req_func = '0;
   logic [ID_W-1:0] req_entry_id = '0;
   logic signed [DIST_W-1:0] req_distance = '0;
   logic rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0] rsp_chosen_id;
   logic rsp_quantum_expired;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [7:0] csr_wdata = '0;

   ready_queue_quantum_scheduler_top #(.QUEUE_DEPTH(DEPTH)) u_dut (.*);

   always #5 clock = ~clock;

   // shadow scheduler state
   entry_type ready_q[$];
   logic sh_nearest = 1'b0;
   logic [7:0] sh_quantum = 8'd3;

   event_type pending_events[$];
   outcome_type expected_outcomes[$];
   int errors = 0;
   int cycles = 0;
   int n_sent = 0;
   int n_checked = 0;
   int idle_pct = 34;
   bit hold_send = 1'b0;

   function automatic int find_entry(logic [ID_W-1:0] id);
      foreach (ready_q[i]) if (ready_q[i].id == id) return i;
      return -1;
   endfunction

   function automatic outcome_type schedule_event(event_type ev);
      outcome_type r;
      int p;
      int best;
      entry_type e;
      r = '0;
      r.status = ST_OK;
      case (ev.func)
         FUNC_ENQUEUE: begin
            if (ready_q.size() >= DEPTH) r.status = ST_FULL;
            else begin
               e = '0;
               e.id = ev.id;
               ready_q.push_back(e);
            end
         end
         FUNC_REMOVE: begin
            p = find_entry(ev.id);
            if (p < 0) r.status = ST_NOT_FOUND;
            else ready_q.delete(p);
         end
         FUNC_CONSUME: begin
            p = find_entry(ev.id);
            if (p < 0) r.status = ST_NOT_FOUND;
            else if (int'(ready_q[p].cnt) + 1 >= int'(sh_quantum)) begin
               e = ready_q[p];
               e.cnt = '0;
               ready_q.delete(p);
               ready_q.push_back(e);
               r.expired = 1'b1;
            end else ready_q[p].cnt = ready_q[p].cnt + 1'b1;
         end
         FUNC_SETDIST: begin
            p = find_entry(ev.id);
            if (p < 0) r.status = ST_NOT_FOUND;
            else if (ev.tdist >= 0) begin
               ready_q[p].tdist = ev.tdist[TD_W-1:0];
               ready_q[p].known = 1'b1;
            end
         end
         FUNC_SELECT: begin
            if (ready_q.size() == 0) r.status = ST_NOT_FOUND;
            else if (!sh_nearest) r.chosen = ready_q[0].id;
            else begin
               best = -1;
               foreach (ready_q[i]) begin
                  if (!ready_q[i].known) begin
                     best = i;
                     break;
                  end
                  if (best < 0 || ready_q[i].tdist < ready_q[best].tdist) best = i;
               end
               r.chosen = ready_q[best].id;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (start && !busy) begin
            expected_outcomes.push_back(schedule_event(
               {req_func, req_entry_id, req_distance}));
            n_sent <= n_sent + 1;
         end
         if ((!start || !busy) && pending_events.size() > 0 && !hold_send
               && $urandom_range(99) >= idle_pct) begin
            event_type ev;
            ev = pending_events.pop_front();
            start <= 1'b1;
            req_func <= ev.func;
            req_entry_id <= ev.id;
            req_distance <= ev.tdist;
         end else if (!start || !busy) begin
            start <= 1'b0;
         end
      end
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         outcome_type w;
         if (expected_outcomes.size() == 0) report_mismatch("unexpected response", 1, 0);
         else begin
            w = expected_outcomes.pop_front();
            if (rsp_status !== w.status) report_mismatch("status", rsp_status, w.status);
            if (rsp_chosen_id !== w.chosen) report_mismatch("chosen_id", rsp_chosen_id, w.chosen);
            if (rsp_quantum_expired !== w.expired)
               report_mismatch("quantum_expired", rsp_quantum_expired, w.expired);
            n_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout");
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic add_event(logic [2:0] f, logic [7:0] id, logic signed [10:0] d);
      event_type ev;
      ev.func = f;
      ev.id = id;
      ev.tdist = d;
      pending_events.push_back(ev);
   endtask

   task automatic drain();
      while (pending_events.size() > 0 || start
             || expected_outcomes.size() > 0 || busy) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [7:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_NEAREST_MODE) sh_nearest = val[0];
      else sh_quantum = val;
   endtask

   function automatic logic [7:0] pick_id();
      // small pool so ids hit often, with occasional wide values
      if ($urandom_range(9) == 0) return 8'($urandom_range(255));
      return 8'($urandom_range(5)) | ($urandom_range(1) ? 8'hF0 : 8'h00);
   endfunction

   function automatic logic signed [10:0] pick_dist();
      case ($urandom_range(5))
         0: return -11'sd1;
         1: return 11'sd1023;
         2: return 11'sd0;
         3: return 11'($urandom_range(2047));
         default: return 11'($urandom_range(20));
      endcase
   endfunction

   initial begin
      int phase;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // directed: empty select, misses, fill past full, extremes
      add_event(FUNC_SELECT, 8'd0, 11'sd0);
      add_event(FUNC_REMOVE, 8'd7, 11'sd0);
      add_event(FUNC_CONSUME, 8'd7, 11'sd0);
      add_event(FUNC_SETDIST, 8'd7, 11'sd5);
      for (int i = 0; i < 17; i++) add_event(FUNC_ENQUEUE, (i == 0) ? 8'hFF : 8'(i), 11'sd0);
      add_event(FUNC_ENQUEUE, 8'd1, 11'sd0);
      add_event(FUNC_SETDIST, 8'hFF, -11'sd1);
      add_event(FUNC_SETDIST, 8'hFF, 11'sd1023);
      add_event(3'd5, 8'hAA, -11'sd1024);
      add_event(3'd7, 8'h55, 11'sd0);
      drain();
      write_csr(CSR_NEAREST_MODE, 8'h01);
      write_csr(CSR_QUANTUM, 8'd1);
      for (int i = 0; i < 16; i++) add_event(FUNC_SETDIST, 8'(i), 11'(i * 37 % 11));
      add_event(FUNC_SELECT, 8'd0, 11'sd0);
      add_event(FUNC_CONSUME, 8'hFF, 11'sd0);
      add_event(FUNC_REMOVE, 8'd1, 11'sd0);
      add_event(FUNC_SELECT, 8'd0, 11'sd0);
      drain();
      for (phase = 0; phase < 8; phase++) begin
         write_csr(CSR_NEAREST_MODE, 8'(phase & 1));
         case (phase % 4)
            0: write_csr(CSR_QUANTUM, 8'd255);
            1: write_csr(CSR_QUANTUM, 8'd0);
            2: write_csr(CSR_QUANTUM, 8'd2);
            default: write_csr(CSR_QUANTUM, 8'($urandom_range(1, 6)));
         endcase
         idle_pct = (phase == 5) ? 0 : 34;
         for (int i = 0; i < 100; i++) begin
            int r;
            r = $urandom_range(99);
            if (r < 18) add_event(FUNC_ENQUEUE, pick_id(), 11'($urandom_range(2047)));
            else if (r < 30) add_event(FUNC_REMOVE, pick_id(), 11'($urandom_range(2047)));
            else if (r < 55) add_event(FUNC_CONSUME, pick_id(), 11'($urandom_range(2047)));
            else if (r < 72) add_event(FUNC_SETDIST, pick_id(), pick_dist());
            else if (r < 97) add_event(FUNC_SELECT, 8'($urandom_range(255)), pick_dist());
            else add_event(3'($urandom_range(5, 7)), pick_id(), pick_dist());
         end
         if (phase == 3) begin
            while (pending_events.size() > 50) @(posedge clock);
            hold_send = 1'b1;
            repeat (2) @(posedge clock);
            while (start || busy || expected_outcomes.size() > 0) @(posedge clock);
            hold_send = 1'b0;
         end
         drain();
      end
      $display("Sent %0d transactions, checked %0d responses", n_sent, n_checked);
      $display("Covered both select modes, quantum 0/1/2/255, full and empty queue");
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+sv
sv/rqqs_pkg.sv
sv/rqqs_mem.sv
sv/ready_queue_quantum_scheduler_top.sv
sim/tb.sv
